/* hw/rtl/gmm_pkg.sv */
// Shared types, widths and codes for the gossip membership merge table.
`timescale 1ns / 1ps
`default_nettype none

package gmm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int KEY_W      = IP_W + PORT_W;
    localparam int STATUS_W   = 3;
    localparam int INC_W      = 32;
    localparam int TIME_W     = 64;
    localparam int OUT_SLOT_W = 6;
    localparam int CFG_DATA_W = 32;

    localparam int IN_FIELDS_W  = IP_W + PORT_W + STATUS_W + INC_W + TIME_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 + OUT_SLOT_W + STATUS_W + INC_W + TIME_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [OUT_SLOT_W-1:0] out_slot_t;
    typedef logic [KEY_W-1:0]      key_t;

    localparam logic OP_MERGE = 1'b0;
    localparam logic OP_FORCE = 1'b1;

    localparam logic REG_SELF_IP   = 1'b0;
    localparam logic REG_SELF_PORT = 1'b1;

    typedef enum logic [2:0] {
        OUT_INSERTED = 3'd0,
        OUT_REPLACED = 3'd1,
        OUT_STALE    = 3'd2,
        OUT_CONFLICT = 3'd3,
        OUT_SELF     = 3'd4,
        OUT_FULL     = 3'd5
    } outcome_t;

    // What the key lookup decided for a request
    typedef enum logic [1:0] {
        KIND_SELF,
        KIND_FULL,
        KIND_INSERT,
        KIND_HIT
    } kind_t;

    typedef struct packed {
        logic                opcode;
        logic [IP_W-1:0]     peer_ip;
        logic [PORT_W-1:0]   peer_port;
        logic [STATUS_W-1:0] peer_status;
        logic [INC_W-1:0]    peer_incarnation;
        logic [TIME_W-1:0]   peer_time;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INC_W-1:0]    incarnation;
        logic [TIME_W-1:0]   stamp;
    } entry_t;

    typedef struct packed {
        kind_t kind;
        slot_t slot;
    } lookup_t;

    typedef struct packed {
        outcome_t  outcome;
        out_slot_t slot;
        entry_t    held;
    } result_t;

    typedef struct packed {
        logic   en;
        slot_t  slot;
        entry_t data;
    } entry_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/gmm_key_cam.sv */
// Associative key store: parallel match, OR-encoded hit slot, append at fill pointer.
`timescale 1ns / 1ps
`default_nettype none

module gmm_key_cam (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gmm_pkg::key_t  lookup_key,
    input  wire logic           insert,
    output gmm_pkg::slot_t      hit_slot,
    output logic                hit,
    output logic                has_room,
    output gmm_pkg::slot_t      fill_slot
);

    gmm_pkg::key_t                       key_reg [gmm_pkg::TABLE_DEPTH];
    logic [gmm_pkg::TABLE_DEPTH-1:0]     valid_reg;
    gmm_pkg::fill_t                      fill_reg;
    logic [gmm_pkg::TABLE_DEPTH-1:0]     match;

    always_comb
    begin
        for (int i = 0; i < gmm_pkg::TABLE_DEPTH; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == lookup_key);
        end
    end

    // Keys are unique, so OR of matching indexes is the matching index
    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < gmm_pkg::TABLE_DEPTH; i++)
        begin
            if (match[i])
            begin
                hit_slot = hit_slot | gmm_pkg::slot_t'(i);
            end
        end
    end

    assign hit       = |match;
    assign has_room  = fill_reg < gmm_pkg::fill_t'(gmm_pkg::TABLE_DEPTH);
    assign fill_slot = fill_reg[gmm_pkg::SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
        end
        else if (insert)
        begin
            valid_reg[fill_slot] <= 1'b1;
            fill_reg             <= fill_reg + gmm_pkg::fill_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            key_reg[fill_slot] <= lookup_key;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/gmm_entry_ram.sv */
// Entry payload memory: status, incarnation and timestamp per slot; registered read.
`timescale 1ns / 1ps
`default_nettype none

module gmm_entry_ram (
    input  wire logic            clk,
    input  wire logic            rd_en,
    input  wire gmm_pkg::slot_t  rd_addr,
    output gmm_pkg::entry_t      rd_data,
    input  wire logic            wr_en,
    input  wire gmm_pkg::slot_t  wr_addr,
    input  wire gmm_pkg::entry_t wr_data
);

    gmm_pkg::entry_t mem [gmm_pkg::TABLE_DEPTH];
    gmm_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/gmm_merge_rule.sv */
// Gossip merge decision for one request: outcome, held entry report and write-back.
`timescale 1ns / 1ps
`default_nettype none

module gmm_merge_rule (
    input  wire gmm_pkg::item_t   item,
    input  wire gmm_pkg::lookup_t look,
    input  wire gmm_pkg::entry_t  held,
    output gmm_pkg::result_t      result,
    output gmm_pkg::entry_wr_t    wr
);

    logic [gmm_pkg::INC_W-1:0] inc_diff;

    // Serial-number compare: held minus incoming negative means incoming is newer
    assign inc_diff = held.incarnation - item.peer_incarnation;

    always_comb
    begin
        result           = '0;
        result.outcome   = gmm_pkg::OUT_REPLACED;
        wr.en            = 1'b0;
        wr.slot          = look.slot;
        wr.data.status      = item.peer_status;
        wr.data.incarnation = item.peer_incarnation;
        wr.data.stamp       = item.peer_time;
        case (look.kind)
            gmm_pkg::KIND_SELF:
            begin
                result.outcome = gmm_pkg::OUT_SELF;
            end
            gmm_pkg::KIND_FULL:
            begin
                result.outcome = gmm_pkg::OUT_FULL;
            end
            gmm_pkg::KIND_INSERT:
            begin
                result.outcome = gmm_pkg::OUT_INSERTED;
                result.slot    = gmm_pkg::out_slot_t'(look.slot);
                wr.en          = 1'b1;
            end
            gmm_pkg::KIND_HIT:
            begin
                result.slot = gmm_pkg::out_slot_t'(look.slot);
                if (item.opcode == gmm_pkg::OP_FORCE || inc_diff[gmm_pkg::INC_W-1])
                begin
                    wr.en = 1'b1;
                end
                else if (held.stamp >= item.peer_time)
                begin
                    result.outcome = gmm_pkg::OUT_STALE;
                end
                else if (held.status > item.peer_status)
                begin
                    result.outcome = gmm_pkg::OUT_CONFLICT;
                    result.held    = held;
                end
                else
                begin
                    wr.en = 1'b1;
                end
            end
            default:
            begin
                result.outcome = gmm_pkg::OUT_SELF;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/gossip_membership_merge_table_unit.sv */
// Top level of the gossip membership merge table.
// An accepted request passes through the s1 registers, then the s2 registers, then the output register to m_axis.
// Throughput: one request per cycle; the pipeline stalls only when m_axis_tready is low.
// Key match and insert happen in the first stage, payload read in the same cycle,
// merge decision and payload write-back in the second, with a bypass for back-to-back slots.
// Reset empties the table (valid bits and fill count) and clears self address and port.
`timescale 1ns / 1ps
`default_nettype none

module gossip_membership_merge_table_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [gmm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // peer_ip, peer_port, peer_status, peer_incarnation, peer_time, zero pad
    input  wire logic [gmm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // outcome, slot, held_status, held_incarnation, held_time, zero pad
    output logic [gmm_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

    logic                          advance;
    gmm_pkg::item_t                in_item;

    logic [gmm_pkg::IP_W-1:0]      self_ip_reg;
    logic [gmm_pkg::PORT_W-1:0]    self_port_reg;

    logic                          s1_valid_reg;
    gmm_pkg::item_t                s1_item_reg;
    gmm_pkg::key_t                 s1_key;
    logic                          s1_is_self;
    gmm_pkg::lookup_t              s1_look;
    logic                          cam_insert;
    logic                          cam_hit;
    logic                          cam_room;
    gmm_pkg::slot_t                cam_hit_slot;
    gmm_pkg::slot_t                cam_fill_slot;

    logic                          s2_valid_reg;
    gmm_pkg::item_t                s2_item_reg;
    gmm_pkg::lookup_t              s2_look_reg;
    gmm_pkg::entry_t               ram_rd_data;
    gmm_pkg::entry_t               s2_held;
    gmm_pkg::result_t              s2_result;
    gmm_pkg::entry_wr_t            s2_wr;
    logic                          ram_wr_en;

    logic                          fwd_valid_reg;
    gmm_pkg::slot_t                fwd_slot_reg;
    gmm_pkg::entry_t               fwd_data_reg;

    logic                          out_valid_reg;
    gmm_pkg::result_t              out_result_reg;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    assign in_item.opcode           = s_axis_tuser;
    assign in_item.peer_ip          = s_axis_tdata[31:0];
    assign in_item.peer_port        = s_axis_tdata[47:32];
    assign in_item.peer_status      = s_axis_tdata[50:48];
    assign in_item.peer_incarnation = s_axis_tdata[82:51];
    assign in_item.peer_time        = s_axis_tdata[146:83];

    // Stage 1: key lookup, self check, append decision
    assign s1_key     = {s1_item_reg.peer_ip, s1_item_reg.peer_port};
    assign s1_is_self = (s1_item_reg.opcode == gmm_pkg::OP_MERGE)
                        && (s1_key == {self_ip_reg, self_port_reg});

    always_comb
    begin
        s1_look.slot = cam_hit ? cam_hit_slot : cam_fill_slot;
        if (s1_is_self)
        begin
            s1_look.kind = gmm_pkg::KIND_SELF;
        end
        else if (cam_hit)
        begin
            s1_look.kind = gmm_pkg::KIND_HIT;
        end
        else if (cam_room)
        begin
            s1_look.kind = gmm_pkg::KIND_INSERT;
        end
        else
        begin
            s1_look.kind = gmm_pkg::KIND_FULL;
        end
    end

    assign cam_insert = advance && s1_valid_reg && (s1_look.kind == gmm_pkg::KIND_INSERT);

    gmm_key_cam u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .lookup_key (s1_key),
        .insert     (cam_insert),
        .hit_slot   (cam_hit_slot),
        .hit        (cam_hit),
        .has_room   (cam_room),
        .fill_slot  (cam_fill_slot)
    );

    assign ram_wr_en = advance && s2_valid_reg && s2_wr.en;

    gmm_entry_ram u_ram (
        .clk     (clk),
        .rd_en   (advance),
        .rd_addr (s1_look.slot),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (s2_wr.slot),
        .wr_data (s2_wr.data)
    );

    // Stage 2: the read raced the previous request's write to the same slot
    assign s2_held = (fwd_valid_reg && (fwd_slot_reg == s2_look_reg.slot))
                     ? fwd_data_reg : ram_rd_data;

    gmm_merge_rule u_rule (
        .item   (s2_item_reg),
        .look   (s2_look_reg),
        .held   (s2_held),
        .result (s2_result),
        .wr     (s2_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_ip_reg   <= '0;
            self_port_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gmm_pkg::REG_SELF_IP:   self_ip_reg   <= cfg_data[gmm_pkg::IP_W-1:0];
                    gmm_pkg::REG_SELF_PORT: self_port_reg <= cfg_data[gmm_pkg::PORT_W-1:0];
                    default:                self_ip_reg   <= self_ip_reg;
                endcase
            end
            if (advance)
            begin
                s1_valid_reg  <= s_axis_tvalid;
                s2_valid_reg  <= s1_valid_reg;
                fwd_valid_reg <= s2_valid_reg && s2_wr.en;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg    <= in_item;
            s2_item_reg    <= s1_item_reg;
            s2_look_reg    <= s1_look;
            fwd_slot_reg   <= s2_wr.slot;
            fwd_data_reg   <= s2_wr.data;
            out_result_reg <= s2_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(gmm_pkg::OUT_DATA_W - gmm_pkg::OUT_FIELDS_W){1'b0}},
        out_result_reg.held.stamp,
        out_result_reg.held.incarnation,
        out_result_reg.held.status,
        out_result_reg.slot,
        out_result_reg.outcome
    };

endmodule

`default_nettype wire
